### rtl/multi_level_page_table_unit_defines.svh
// assertion macros for the page table walk unit
// used by the checker; expects clk and rst_n in scope
`ifndef MULTI_LEVEL_PAGE_TABLE_UNIT_DEFINES_SVH
`define MULTI_LEVEL_PAGE_TABLE_UNIT_DEFINES_SVH

// checked only outside reset
`define MLPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define MLPT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/mlpt_pkg.sv
// shared constants, types and index helper for the page table walk unit
// no dependencies
`default_nettype none

package mlpt_pkg;

  localparam int OFFSET_BITS = 12;
  localparam int LEVEL_COUNT = 2;
  localparam int FRAME_COUNT = 64;

  localparam int INDEX_BITS = OFFSET_BITS - 3;
  localparam int FRAME_W    = $clog2(FRAME_COUNT);
  localparam int NF_W       = $clog2(FRAME_COUNT + 1);
  localparam int ADDR_W     = FRAME_W + INDEX_BITS;
  localparam int LVL_W      = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

  localparam int VA_W   = 30;
  localparam int PA_W   = 52;
  localparam int BASE_W = 40;
  localparam int ST_W   = 2;
  localparam int VX_W   = (VA_W > OFFSET_BITS + LEVEL_COUNT * INDEX_BITS) ?
                          VA_W : OFFSET_BITS + LEVEL_COUNT * INDEX_BITS;

  localparam int IN_TDATA_W  = ((VA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((PA_W + ST_W + 7) / 8) * 8;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_UNMAPPED  = 2'd1;
  localparam logic [ST_W-1:0] ST_NO_FRAMES = 2'd2;

  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_ALLOCATE  = 1'b1;

  typedef logic [FRAME_W-1:0] frame_t;

  typedef struct packed {
    frame_t frame;
    logic   valid;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic            cmd;
    logic [VA_W-1:0] va;
  } mlpt_req_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [PA_W-1:0] pa;
  } mlpt_res_t;

  // index field of one level, top level first
  function automatic logic [INDEX_BITS-1:0] level_index(input logic [VA_W-1:0] va,
                                                        input logic [LVL_W-1:0] lvl);
    logic [VX_W-1:0]       vx;
    logic [INDEX_BITS-1:0] idx;
    vx  = VX_W'(va);
    idx = '0;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      if (lvl == LVL_W'(i)) begin
        idx = vx[OFFSET_BITS + (LEVEL_COUNT - 1 - i) * INDEX_BITS +: INDEX_BITS];
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

### rtl/mlpt_ram.sv
// simple dual port synchronous ram, one write and one registered read port
// no dependencies
`default_nettype none

module mlpt_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/mlpt_walk.sv
// table walk sequencer: root pointer, bump frame counter, table memory
// depends on mlpt_pkg and mlpt_ram
`default_nettype none

module mlpt_walk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  mlpt_pkg::mlpt_req_t           req,
  input  logic [mlpt_pkg::BASE_W-1:0]   frame_base,
  output logic                          res_valid,
  input  logic                          res_ready,
  output mlpt_pkg::mlpt_res_t           res
);

  import mlpt_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_CHK   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  entry_t            root_r, root_nxt;
  logic [NF_W-1:0]   nf_r, nf_nxt;
  mlpt_req_t         req_r, req_nxt;
  frame_t            frame_r, frame_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  mlpt_res_t         res_r, res_nxt;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_data;

  logic              accept;
  logic              nf_avail;
  frame_t            nf_frame;
  frame_t            walk_frame;
  logic              walk_go;
  logic [BASE_W:0]   pfn;

  mlpt_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req_ready = (state_r == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign nf_avail  = (nf_r < NF_W'(FRAME_COUNT));
  assign nf_frame  = nf_r[FRAME_W-1:0];
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // a slot written at one level lies in another frame than the next read,
  // so write and read never meet on one entry
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    root_nxt   = root_r;
    nf_nxt     = nf_r;
    req_nxt    = req_r;
    frame_nxt  = frame_r;
    lvl_nxt    = lvl_r;
    res_nxt    = res_r;
    wr_en      = 1'b0;
    wr_addr    = clr_r;
    wr_data    = '0;
    rd_en      = 1'b0;
    rd_addr    = {frame_r, level_index(req_r.va, lvl_r)};
    walk_frame = rd_data.frame;
    walk_go    = 1'b0;
    pfn        = '0;

    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          req_nxt = req;
          lvl_nxt = '0;
          if (root_r.valid) begin
            frame_nxt = root_r.frame;
            rd_en     = 1'b1;
            rd_addr   = {root_r.frame, level_index(req.va, '0)};
            state_nxt = S_CHK;
          end else if (req.cmd == CMD_TRANSLATE) begin
            res_nxt   = '{status: ST_UNMAPPED, pa: '0};
            state_nxt = S_DONE;
          end else if (!nf_avail) begin
            res_nxt   = '{status: ST_NO_FRAMES, pa: '0};
            state_nxt = S_DONE;
          end else begin
            root_nxt  = '{frame: nf_frame, valid: 1'b1};
            nf_nxt    = nf_r + 1'b1;
            frame_nxt = nf_frame;
            rd_en     = 1'b1;
            rd_addr   = {nf_frame, level_index(req.va, '0)};
            state_nxt = S_CHK;
          end
        end
      end

      S_CHK: begin
        if (rd_data.valid) begin
          walk_frame = rd_data.frame;
          walk_go    = 1'b1;
        end else if (req_r.cmd == CMD_TRANSLATE) begin
          res_nxt   = '{status: ST_UNMAPPED, pa: '0};
          state_nxt = S_DONE;
        end else if (!nf_avail) begin
          res_nxt   = '{status: ST_NO_FRAMES, pa: '0};
          state_nxt = S_DONE;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = {frame_r, level_index(req_r.va, lvl_r)};
          wr_data    = '{frame: nf_frame, valid: 1'b1};
          nf_nxt     = nf_r + 1'b1;
          walk_frame = nf_frame;
          walk_go    = 1'b1;
        end
        if (walk_go) begin
          frame_nxt = walk_frame;
          if (lvl_r == LVL_W'(LEVEL_COUNT - 1)) begin
            pfn       = (BASE_W + 1)'(frame_base) + (BASE_W + 1)'(walk_frame);
            res_nxt   = '{status: ST_OK,
                          pa: PA_W'({pfn, req_r.va[OFFSET_BITS-1:0]})};
            state_nxt = S_DONE;
          end else begin
            lvl_nxt = LVL_W'(lvl_r + 1'b1);
            rd_en   = 1'b1;
            rd_addr = {walk_frame, level_index(req_r.va, LVL_W'(lvl_r + 1'b1))};
          end
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      root_r  <= '0;
      nf_r    <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      root_r  <= root_nxt;
      nf_r    <= nf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    frame_r <= frame_nxt;
    lvl_r   <= lvl_nxt;
    res_r   <= res_nxt;
  end

endmodule

`default_nettype wire

### rtl/multi_level_page_table_unit.sv
// channel      | dir | handshake          | payload
// in_          | in  | in_tvalid/tready   | tuser: command; tdata: virtual_address
// out_         | out | out_tvalid/tready  | tdata: physical_address, status
// cfg_         | in  | cfg_wr_en          | cfg_wr_data: frame_base
// an item passes through accept, one table memory read per level, then the handoff
// to the output register; a fault ends the walk early
// after reset a clearing pass over all 2^ADDR_W entries (32768) empties the table memory;
// in_tready stays low meanwhile, configuration writes are taken as ever
// the output register lets a new transaction enter while a result waits
// depends on mlpt_pkg and mlpt_walk
`default_nettype none

module multi_level_page_table_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mlpt_pkg::IN_TDATA_W-1:0]     in_tdata,    // virtual_address, zero pad
  input  logic                                in_tuser,    // command
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mlpt_pkg::OUT_TDATA_W-1:0]    out_tdata,   // physical_address, status, zero pad
  input  logic                                cfg_wr_en,
  input  logic [mlpt_pkg::BASE_W-1:0]         cfg_wr_data  // frame_base
);

  import mlpt_pkg::*;

  logic [BASE_W-1:0]      frame_base_r;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  mlpt_req_t              req;
  mlpt_res_t              res;
  logic                   res_valid;
  logic                   res_ready;

  assign req.cmd = in_tuser;
  assign req.va  = in_tdata[VA_W-1:0];

  mlpt_walk u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req        (req),
    .frame_base (frame_base_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res_valid && res_ready) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        frame_base_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_tdata_r <= OUT_TDATA_W'(res);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

### rtl/mlpt_checker.sv
// port level checks for the page table walk unit, bound to the top level
// depends on mlpt_pkg and multi_level_page_table_unit_defines.svh
`default_nettype none
`include "multi_level_page_table_unit_defines.svh"

module mlpt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [mlpt_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import mlpt_pkg::*;

  `MLPT_ASSERT_RST(a_reset_quiet, !rst_n |=> !in_tready && !out_tvalid, "busy after reset")
  `MLPT_ASSERT(a_one_at_a_time, in_tvalid && in_tready |=> !in_tready, "second transaction taken")
  `MLPT_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result dropped")
  `MLPT_ASSERT(a_status_code, out_tvalid |-> out_tdata[PA_W +: ST_W] == ST_OK || out_tdata[PA_W +: ST_W] == ST_UNMAPPED || out_tdata[PA_W +: ST_W] == ST_NO_FRAMES, "bad status")
  `MLPT_ASSERT(a_fault_zero, out_tvalid && out_tdata[PA_W +: ST_W] != ST_OK |-> out_tdata[PA_W-1:0] == '0, "fault with address")

endmodule

bind multi_level_page_table_unit mlpt_checker u_checker (.*);

`default_nettype wire
